/* rtl/core/armm_pkg.sv */
// ----------------------------------------------------------------------------
// armm_pkg
// shared widths, register defaults and codes of the antenna rate and motion
// monitor
// ----------------------------------------------------------------------------
package armm_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF  = 48;

  localparam int unsigned SUM_BITS      = 32;
  localparam int unsigned RATE_BITS     = 24;
  localparam int unsigned SECS_BITS     = 28;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned INTERVAL_BITS = 32;
  localparam int unsigned LIMIT_BITS    = 48;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 48;

  // microseconds per second and the width of the scaled angle sum
  localparam int unsigned USEC_BITS = 20;
  localparam logic [USEC_BITS-1:0] USEC_PER_SEC = 20'd1000000;
  localparam int unsigned PROD_BITS = 51;

  // degrees per turn, for the one degree movement test
  localparam int unsigned DEG_PER_TURN = 360;

  localparam logic [INTERVAL_BITS-1:0] RATE_INTERVAL_RST   = 32'd1000000;
  localparam logic [INTERVAL_BITS-1:0] MOTION_INTERVAL_RST = 32'd1000000;
  localparam logic [LIMIT_BITS-1:0]    WARN_AFTER_RST      = 48'd30000000;
  localparam logic [LIMIT_BITS-1:0]    CRITICAL_AFTER_RST  = 48'd120000000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RATE_INTERVAL   = 3'd0,
    CFG_MOTION_INTERVAL = 3'd1,
    CFG_WARN_AFTER      = 3'd2,
    CFG_CRITICAL_AFTER  = 3'd3,
    CFG_MOTION_ENABLE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [STATUS_BITS-1:0] {
    MS_OK   = 2'd0,
    MS_WARN = 2'd1,
    MS_CRIT = 2'd2
  } status_t;

endpackage

/* rtl/core/armm_if.sv */
// ----------------------------------------------------------------------------
// armm_if
// valid/ready channels of the monitor: angle samples, results and
// register writes
// ----------------------------------------------------------------------------
interface armm_in_if #(
  parameter int unsigned ANGLE_BITS = armm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TIME_BITS  = armm_pkg::TIME_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] azimuth;
  logic [ANGLE_BITS-1:0] elevation;
  logic [TIME_BITS-1:0]  time_us;

  modport source (output valid, azimuth, elevation, time_us, input ready);
  modport sink   (input valid, azimuth, elevation, time_us, output ready);
endinterface

interface armm_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [armm_pkg::RATE_BITS-1:0]     rate_az;
  logic signed [armm_pkg::RATE_BITS-1:0]     rate_el;
  logic                                      rate_updated;
  logic                                      check_done;
  logic        [armm_pkg::STATUS_BITS-1:0]   motion_status;
  logic        [armm_pkg::SECS_BITS-1:0]     stopped_seconds;

  modport source (output valid, rate_az, rate_el, rate_updated, check_done,
                  motion_status, stopped_seconds, input ready);
  modport sink   (input valid, rate_az, rate_el, rate_updated, check_done,
                  motion_status, stopped_seconds, output ready);
endinterface

interface armm_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [armm_pkg::CFG_IDX_BITS-1:0]  index;
  logic [armm_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/armm_sdiv.sv */
// ----------------------------------------------------------------------------
// armm_sdiv
// bit-serial restoring divider, one quotient bit per cycle, keeping the low
// quotient bits and a sticky flag for any higher bit
// ----------------------------------------------------------------------------
module armm_sdiv #(
  parameter int unsigned DVD_BITS = armm_pkg::PROD_BITS,
  parameter int unsigned DVS_BITS = armm_pkg::TIME_BITS_DEF,
  parameter int unsigned QUO_BITS = armm_pkg::RATE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                busy,
  output logic [QUO_BITS-1:0] quotient,
  output logic                overflow
);

  localparam int unsigned CNT_BITS = $clog2(DVD_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic [DVD_BITS-1:0] dvd;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS-1:0] rem_next;
  logic [DVS_BITS:0]   trial;
  logic [DVS_BITS:0]   diff;
  logic                ge;

  assign trial    = {rem, dvd[DVD_BITS-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign rem_next = ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(DVD_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
      overflow <= 1'b0;
    end else if (busy) begin
      dvd      <= {dvd[DVD_BITS-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[QUO_BITS-2:0], ge};
      overflow <= overflow | quotient[QUO_BITS-1];
    end
  end

endmodule

/* rtl/core/antenna_rate_motion_monitor_unit.sv */
// ----------------------------------------------------------------------------
// antenna_rate_motion_monitor_unit: azimuth/elevation rate and motion monitor
// items with a rate update or motion check go S_PREP, S_LOAD, then S_DIV until the
// bit-serial dividers finish, then S_DONE; others go from S_PREP to S_DONE
// one item at a time, next item taken in S_IDLE, entered as its result is stored
// synchronous reset restores register defaults and clears all monitor state
// ----------------------------------------------------------------------------
module antenna_rate_motion_monitor_unit #(
  parameter int unsigned ANGLE_BITS = armm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned TIME_BITS  = armm_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  armm_in_if.sink    sample,
  armm_out_if.source result,
  armm_cfg_if.sink   cfg
);

  localparam int unsigned SUM_BITS   = armm_pkg::SUM_BITS;
  localparam int unsigned RATE_BITS  = armm_pkg::RATE_BITS;
  localparam int unsigned SECS_BITS  = armm_pkg::SECS_BITS;
  localparam int unsigned PROD_BITS  = armm_pkg::PROD_BITS;
  localparam int unsigned USEC_BITS  = armm_pkg::USEC_BITS;
  localparam int unsigned LIMIT_BITS = armm_pkg::LIMIT_BITS;
  localparam int unsigned CMP_BITS   = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;
  localparam int unsigned DEG_BITS   = ANGLE_BITS + 10;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [armm_pkg::INTERVAL_BITS-1:0] rate_interval;
  logic [armm_pkg::INTERVAL_BITS-1:0] motion_interval;
  logic [LIMIT_BITS-1:0]              warn_after;
  logic [LIMIT_BITS-1:0]              critical_after;
  logic                               motion_en;

  logic                        seeded;
  logic [ANGLE_BITS-1:0]       prev_az;
  logic [ANGLE_BITS-1:0]       prev_el;
  logic signed [SUM_BITS-1:0]  sum_az;
  logic signed [SUM_BITS-1:0]  sum_el;
  logic [TIME_BITS-1:0]        win_start;
  logic signed [RATE_BITS-1:0] held_az;
  logic signed [RATE_BITS-1:0] held_el;
  logic [ANGLE_BITS-1:0]       ref_az;
  logic [ANGLE_BITS-1:0]       ref_el;
  logic [TIME_BITS-1:0]        last_check;
  logic [TIME_BITS-1:0]        stop_time;

  logic [ANGLE_BITS-1:0]       s_az;
  logic [ANGLE_BITS-1:0]       s_el;
  logic [TIME_BITS-1:0]        s_t;
  logic signed [SUM_BITS-1:0]  div_sum_az;
  logic signed [SUM_BITS-1:0]  div_sum_el;
  logic [TIME_BITS-1:0]        elapsed;
  logic [TIME_BITS-1:0]        stopped;
  logic                        upd;
  logic                        chk;
  armm_pkg::status_t           status;

  logic                        res_valid;
  logic                        res_load;

  logic signed [SUM_BITS-1:0]  sum_az_new;
  logic signed [SUM_BITS-1:0]  sum_el_new;
  logic [TIME_BITS-1:0]        elapsed_c;
  logic [TIME_BITS-1:0]        since_check;
  logic [TIME_BITS-1:0]        since_stop;
  logic                        upd_c;
  logic                        chk_c;
  logic                        moved;
  logic [SUM_BITS-1:0]         mag_az;
  logic [SUM_BITS-1:0]         mag_el;
  logic [PROD_BITS-1:0]        prod_az;
  logic [PROD_BITS-1:0]        prod_el;
  logic [CMP_BITS-1:0]         stopped_cmp;
  logic                        div_start;

  logic                        busy_az;
  logic                        busy_el;
  logic                        busy_secs;
  logic [RATE_BITS-1:0]        quo_az;
  logic [RATE_BITS-1:0]        quo_el;
  logic [SECS_BITS-1:0]        quo_secs;
  logic                        ovf_az;
  logic                        ovf_el;
  logic                        ovf_secs;
  logic signed [RATE_BITS-1:0] rate_az_new;
  logic signed [RATE_BITS-1:0] rate_el_new;

  function automatic logic signed [ANGLE_BITS:0] wrap_delta(
    input logic [ANGLE_BITS-1:0] now,
    input logic [ANGLE_BITS-1:0] old
  );
    logic [ANGLE_BITS-1:0] d;
    d = now - old;
    return {(d > {1'b1, {(ANGLE_BITS-1){1'b0}}}), d};
  endfunction

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0] a,
    input logic signed [ANGLE_BITS:0] b
  );
    logic signed [SUM_BITS:0] s;
    logic signed [SUM_BITS-1:0] r;
    s = (SUM_BITS+1)'(a) + (SUM_BITS+1)'(b);
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      r = s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      r = s[SUM_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic over_degree(
    input logic [ANGLE_BITS-1:0] now,
    input logic [ANGLE_BITS-1:0] old
  );
    logic signed [ANGLE_BITS:0] d;
    logic [ANGLE_BITS:0]        mag;
    d   = wrap_delta(now, old);
    mag = d[ANGLE_BITS] ? (ANGLE_BITS+1)'(-d) : (ANGLE_BITS+1)'(d);
    return (DEG_BITS'(mag) * DEG_BITS'(armm_pkg::DEG_PER_TURN)) >
           (DEG_BITS'(1) << ANGLE_BITS);
  endfunction

  function automatic logic signed [RATE_BITS-1:0] sat_rate(
    input logic                 neg,
    input logic [RATE_BITS-1:0] q,
    input logic                 ovf
  );
    logic big;
    logic signed [RATE_BITS-1:0] r;
    big = ovf | q[RATE_BITS-1];
    if (neg) begin
      r = big ? {1'b1, {(RATE_BITS-1){1'b0}}} : -q;
    end else begin
      r = big ? {1'b0, {(RATE_BITS-1){1'b1}}} : q;
    end
    return r;
  endfunction

  // register port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_interval   <= armm_pkg::RATE_INTERVAL_RST;
      motion_interval <= armm_pkg::MOTION_INTERVAL_RST;
      warn_after      <= armm_pkg::WARN_AFTER_RST;
      critical_after  <= armm_pkg::CRITICAL_AFTER_RST;
      motion_en       <= 1'b1;
    end else if (cfg.valid) begin
      case (armm_pkg::cfg_idx_t'(cfg.index))
        armm_pkg::CFG_RATE_INTERVAL: begin
          rate_interval <= cfg.data[armm_pkg::INTERVAL_BITS-1:0];
        end
        armm_pkg::CFG_MOTION_INTERVAL: begin
          motion_interval <= cfg.data[armm_pkg::INTERVAL_BITS-1:0];
        end
        armm_pkg::CFG_WARN_AFTER: begin
          warn_after <= cfg.data[LIMIT_BITS-1:0];
        end
        armm_pkg::CFG_CRITICAL_AFTER: begin
          critical_after <= cfg.data[LIMIT_BITS-1:0];
        end
        armm_pkg::CFG_MOTION_ENABLE: begin
          motion_en <= cfg.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // per-sample update terms
  assign sum_az_new  = sat_add(sum_az, wrap_delta(s_az, prev_az));
  assign sum_el_new  = sat_add(sum_el, wrap_delta(s_el, prev_el));
  assign elapsed_c   = s_t - win_start;
  assign since_check = s_t - last_check;
  assign since_stop  = s_t - stop_time;
  assign upd_c       = elapsed_c > TIME_BITS'(rate_interval);
  assign chk_c       = motion_en && (since_check >= TIME_BITS'(motion_interval));
  assign moved       = over_degree(s_el, ref_el) || over_degree(s_az, ref_az);

  // scaled magnitudes for the rate division
  assign mag_az  = div_sum_az[SUM_BITS-1] ? SUM_BITS'(-div_sum_az) : SUM_BITS'(div_sum_az);
  assign mag_el  = div_sum_el[SUM_BITS-1] ? SUM_BITS'(-div_sum_el) : SUM_BITS'(div_sum_el);
  assign prod_az = PROD_BITS'(mag_az) * PROD_BITS'(armm_pkg::USEC_PER_SEC);
  assign prod_el = PROD_BITS'(mag_el) * PROD_BITS'(armm_pkg::USEC_PER_SEC);

  assign stopped_cmp = CMP_BITS'(stopped);
  assign div_start   = (state == S_LOAD);

  armm_sdiv #(
    .DVD_BITS (PROD_BITS),
    .DVS_BITS (TIME_BITS),
    .QUO_BITS (RATE_BITS)
  ) u_div_az (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_az),
    .divisor  (elapsed),
    .busy     (busy_az),
    .quotient (quo_az),
    .overflow (ovf_az)
  );

  armm_sdiv #(
    .DVD_BITS (PROD_BITS),
    .DVS_BITS (TIME_BITS),
    .QUO_BITS (RATE_BITS)
  ) u_div_el (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_el),
    .divisor  (elapsed),
    .busy     (busy_el),
    .quotient (quo_el),
    .overflow (ovf_el)
  );

  armm_sdiv #(
    .DVD_BITS (TIME_BITS),
    .DVS_BITS (USEC_BITS),
    .QUO_BITS (SECS_BITS)
  ) u_div_secs (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (stopped),
    .divisor  (armm_pkg::USEC_PER_SEC),
    .busy     (busy_secs),
    .quotient (quo_secs),
    .overflow (ovf_secs)
  );

  assign rate_az_new = sat_rate(div_sum_az[SUM_BITS-1], quo_az, ovf_az);
  assign rate_el_new = sat_rate(div_sum_el[SUM_BITS-1], quo_el, ovf_el);

  assign sample.ready = (state == S_IDLE);
  assign res_load     = (state == S_DONE) && (!res_valid || result.ready);

  // sequencer and monitor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seeded     <= 1'b0;
      prev_az    <= '0;
      prev_el    <= '0;
      sum_az     <= '0;
      sum_el     <= '0;
      win_start  <= '0;
      held_az    <= '0;
      held_el    <= '0;
      ref_az     <= '0;
      ref_el     <= '0;
      last_check <= '0;
      stop_time  <= '0;
      upd        <= 1'b0;
      chk        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          prev_az <= s_az;
          prev_el <= s_el;
          if (!seeded) begin
            seeded     <= 1'b1;
            sum_az     <= '0;
            sum_el     <= '0;
            held_az    <= '0;
            held_el    <= '0;
            win_start  <= s_t;
            last_check <= s_t;
            upd        <= 1'b0;
            chk        <= 1'b0;
            state      <= S_DONE;
          end else begin
            upd <= upd_c;
            chk <= chk_c;
            if (upd_c) begin
              win_start <= s_t;
              sum_az    <= '0;
              sum_el    <= '0;
            end else begin
              sum_az <= sum_az_new;
              sum_el <= sum_el_new;
            end
            if (chk_c) begin
              last_check <= s_t;
              if (moved) begin
                ref_az    <= s_az;
                ref_el    <= s_el;
                stop_time <= s_t;
              end
            end
            state <= (upd_c || chk_c) ? S_LOAD : S_DONE;
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!busy_az && !busy_el && !busy_secs) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            if (upd) begin
              held_az <= rate_az_new;
              held_el <= rate_el_new;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item capture and division operands
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s_az <= sample.azimuth;
      s_el <= sample.elevation;
      s_t  <= sample.time_us;
    end
    if (state == S_PREP) begin
      div_sum_az <= sum_az_new;
      div_sum_el <= sum_el_new;
      elapsed    <= elapsed_c;
      stopped    <= moved ? '0 : since_stop;
    end
    if (state == S_LOAD) begin
      if (stopped_cmp < CMP_BITS'(warn_after)) begin
        status <= armm_pkg::MS_OK;
      end else if (stopped_cmp < CMP_BITS'(critical_after)) begin
        status <= armm_pkg::MS_WARN;
      end else begin
        status <= armm_pkg::MS_CRIT;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.rate_az      <= upd ? rate_az_new : held_az;
      result.rate_el      <= upd ? rate_el_new : held_el;
      result.rate_updated <= upd;
      result.check_done   <= chk;
      result.motion_status   <= chk ? status : armm_pkg::MS_OK;
      result.stopped_seconds <= !chk ? '0 : (ovf_secs ? '1 : quo_secs);
    end
  end

  assign result.valid = res_valid;

`ifndef SYNTHESIS
  a_accept_to_prep: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == S_PREP))
    else $error("accepted item did not start processing");

  a_no_check_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.check_done) |->
      (result.motion_status == armm_pkg::MS_OK && result.stopped_seconds == '0))
    else $error("motion fields set without a check");

  a_div_idle_at_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!busy_az && !busy_el && !busy_secs))
    else $error("result taken while a divider is running");

  a_seed_clears_rates: assert property (@(posedge clk) disable iff (rst)
    $rose(seeded) |-> (held_az == '0 && held_el == '0))
    else $error("held rates not cleared by seed item");
`endif

endmodule
